@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// Holds screen geometry, command codes, item structs and the internal op record.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam int QDEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [2:0] {
    K_NOP,
    K_PUT,
    K_NEWLINE,
    K_READ,
    K_CLEAR
  } op_kind_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_FILL,
    BK_BLANK
  } back_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  read_col;
    logic [ROW_W-1:0]  read_row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_value;
  } out_item_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  rcol;
    logic [ROW_W-1:0]  rrow;
  } op_t;

endpackage

@@ rtl/core/tcw_front.sv @@
// Front end: accepts commands and classifies them into internal ops.
// Holds one classified op until the queue takes it. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  tcw_pkg::in_item_t item_i,
  input  logic             hold_i,
  input  logic             q_full_i,
  output logic             busy_o,
  output logic             push_o,
  output tcw_pkg::op_t     op_o
);
  import tcw_pkg::*;

  logic valid_r, valid_nxt;
  op_t  op_r, op_nxt;
  op_t  op_cls;
  logic accept;

  always_comb begin
    op_cls.ch   = item_i.char_code;
    op_cls.rcol = item_i.read_col;
    op_cls.rrow = item_i.read_row;
    case (item_i.command)
      CMD_PUT: begin
        op_cls.kind = (item_i.char_code == NEWLINE_CHAR) ? K_NEWLINE : K_PUT;
      end
      CMD_READ: begin
        // out-of-screen reads give a zero cell: treat as no-op
        if (({1'b0, item_i.read_col} < (COL_W+1)'(COLUMNS)) &&
            ({1'b0, item_i.read_row} < (ROW_W+1)'(ROWS))) begin
          op_cls.kind = K_READ;
        end else begin
          op_cls.kind = K_NOP;
        end
      end
      CMD_CLEAR: begin
        op_cls.kind = K_CLEAR;
      end
      default: begin
        op_cls.kind = K_NOP;
      end
    endcase
  end

  assign busy_o  = hold_i | (valid_r & q_full_i);
  assign push_o  = valid_r & ~q_full_i;
  assign op_o    = op_r;
  assign accept  = start_i & ~busy_o;

  always_comb begin
    valid_nxt = valid_r & ~push_o;
    op_nxt    = op_r;
    if (accept) begin
      valid_nxt = 1'b1;
      op_nxt    = op_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    op_r <= op_nxt;
  end

endmodule

@@ rtl/core/tcw_queue.sv @@
// Short op queue between front and back end.
// Register-based ring of QDEPTH entries. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_i,
  input  tcw_pkg::op_t din_i,
  input  logic         pop_i,
  output tcw_pkg::op_t dout_o,
  output logic         valid_o,
  output logic         full_o
);
  import tcw_pkg::*;

  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  op_t               ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign valid_o = (cnt_r != '0);
  assign full_o  = (cnt_r == QCNT_W'(QDEPTH));
  assign dout_o  = ent_r[rp_r];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH-1)) ? '0 : wp_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH-1)) ? '0 : rp_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      ent_r[wp_r] <= din_i;
    end
  end

endmodule

@@ rtl/core/tcw_back.sv @@
// Back end: screen memory, cursor, scroll by row rotation and fill sweeps.
// Executes queued ops and registers one result per op. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    op_valid_i,
  input  tcw_pkg::op_t            op_i,
  output logic                    pop_o,
  input  logic                    cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata_i,
  output logic                    init_o,
  output logic                    res_valid_o,
  output tcw_pkg::out_item_t      res_o
);
  import tcw_pkg::*;

  localparam int LIN_W = ROW_W + COL_W;

  back_state_t        state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic [ATTR_W-1:0]  attr_r;
  logic               out_valid_r;
  out_item_t          out_r, out_nxt;
  logic [CELL_W-1:0]  rd_data_r;
  logic [CELL_W-1:0]  mem [CELL_COUNT];

  logic               we, re, emit, line_feed;
  logic [ADDR_W-1:0]  wa, ra, cur_addr;
  logic [CELL_W-1:0]  wd, blank, cell_val;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] l,
                                                input logic [ROW_W-1:0] t);
    logic [ROW_W:0] s;
    s = {1'b0, l} + {1'b0, t};
    if (s >= (ROW_W+1)'(ROWS)) begin
      s = s - (ROW_W+1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  function automatic logic [POS_W-1:0] lin_pos(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
    logic [LIN_W-1:0] f;
    f = LIN_W'(r) * LIN_W'(COLUMNS) + LIN_W'(c);
    return f[POS_W-1:0];
  endfunction

  assign blank       = {((state_r == BK_INIT) ? RESET_ATTR : attr_r), BLANK_CHAR};
  assign cur_addr    = cell_addr(phys_row(row_r, top_r), col_r);
  assign init_o      = (state_r == BK_INIT);
  assign res_valid_o = out_valid_r;
  assign res_o       = out_r;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    top_nxt   = top_r;
    cnt_nxt   = cnt_r;
    base_nxt  = base_r;
    pop_o     = 1'b0;
    we        = 1'b0;
    wa        = cnt_r;
    wd        = blank;
    re        = 1'b0;
    ra        = cell_addr(phys_row(op_i.rrow, top_r), op_i.rcol);
    emit      = 1'b0;
    line_feed = 1'b0;
    cell_val  = '0;

    case (state_r)
      BK_INIT: begin
        we = 1'b1;
        if (cnt_r == ADDR_W'(CELL_COUNT-1)) begin
          cnt_nxt   = '0;
          state_nxt = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      BK_IDLE: begin
        if (op_valid_i) begin
          pop_o = 1'b1;
          case (op_i.kind)
            K_PUT: begin
              we = 1'b1;
              wa = cur_addr;
              wd = {attr_r, op_i.ch};
              if (col_r == COL_W'(COLUMNS-1)) begin
                line_feed = 1'b1;
              end else begin
                col_nxt = col_r + COL_W'(1);
                emit    = 1'b1;
              end
            end
            K_NEWLINE: begin
              line_feed = 1'b1;
            end
            K_READ: begin
              re        = 1'b1;
              state_nxt = BK_READ;
            end
            K_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = BK_FILL;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
          if (line_feed) begin
            col_nxt = '0;
            if (row_r == ROW_W'(ROWS-1)) begin
              // rotate rows: old top row becomes the blank bottom row
              top_nxt   = (top_r == ROW_W'(ROWS-1)) ? '0 : top_r + ROW_W'(1);
              base_nxt  = cell_addr(top_r, '0);
              cnt_nxt   = '0;
              state_nxt = BK_BLANK;
            end else begin
              row_nxt = row_r + ROW_W'(1);
              emit    = 1'b1;
            end
          end
        end
      end
      BK_READ: begin
        emit      = 1'b1;
        cell_val  = rd_data_r;
        state_nxt = BK_IDLE;
      end
      BK_FILL: begin
        we = 1'b1;
        if (cnt_r == ADDR_W'(CELL_COUNT-1)) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      BK_BLANK: begin
        we = 1'b1;
        wa = base_r + cnt_r;
        if (cnt_r == ADDR_W'(COLUMNS-1)) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    out_nxt.cursor_col      = col_nxt;
    out_nxt.cursor_row      = row_nxt;
    out_nxt.cursor_position = lin_pos(row_nxt, col_nxt);
    out_nxt.cell_value      = cell_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_INIT;
      col_r       <= '0;
      row_r       <= '0;
      top_r       <= '0;
      cnt_r       <= '0;
      attr_r      <= RESET_ATTR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      top_r       <= top_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit;
      if (cfg_we_i) begin
        attr_r <= cfg_wdata_i;
      end
    end
    base_r <= base_nxt;
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= mem[ra];
    end
  end

endmodule

@@ rtl/core/text_console_writer.sv @@
// Result path: front register, op queue, back end result register; a read adds BK_READ,
// a scroll the BK_BLANK sweep of COLUMNS cells, a clear the BK_FILL sweep of all cells.
// Throughput: one plain item per cycle while no read, scroll or clear holds the back end.
// Reset: cursor home, attribute 0x0F; a blanking sweep of all COLUMNS*ROWS cells (2000)
// keeps busy high before the first transfer. Results cannot be stalled by the receiver.
// Top level: ties front end, op queue and back end together. Depends on tcw_pkg.
`timescale 1ns / 1ps

module text_console_writer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  tcw_pkg::in_item_t          in_item,
  output logic                       out_valid,
  output tcw_pkg::out_item_t         out_item,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata
);
  import tcw_pkg::*;

  logic q_push, q_pop, q_valid, q_full, init_busy;
  op_t  front_op, head_op;

  tcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .item_i   (in_item),
    .hold_i   (init_busy),
    .q_full_i (q_full),
    .busy_o   (busy),
    .push_o   (q_push),
    .op_o     (front_op)
  );

  tcw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .din_i   (front_op),
    .pop_i   (q_pop),
    .dout_o  (head_op),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  tcw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .op_valid_i  (q_valid),
    .op_i        (head_op),
    .pop_o       (q_pop),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .init_o      (init_busy),
    .res_valid_o (out_valid),
    .res_o       (out_item)
  );

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, out_item.cursor_col} < (COL_W+1)'(COLUMNS)) &&
                   ({1'b0, out_item.cursor_row} < (ROW_W+1)'(ROWS))))
    else $error("cursor outside screen");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> (busy && !q_valid && !$past(q_pop)))
    else $error("activity during blanking sweep");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(init_busy))
    else $error("result transfer without an op");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for text_console_writer: drives put, read, clear and no-op
// commands in bursts and checks every result strobe against a screen and cursor model.
// Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 1ps

class console_scoreboard;
  logic [tcw_pkg::CELL_W-1:0] cells [tcw_pkg::CELL_COUNT];
  logic [tcw_pkg::COL_W-1:0]  cur_col;
  logic [tcw_pkg::ROW_W-1:0]  cur_row;
  logic [tcw_pkg::ATTR_W-1:0] attr;
  tcw_pkg::out_item_t         expected_q[$];
  int unsigned                failures;

  function new();
    attr     = tcw_pkg::RESET_ATTR;
    cur_col  = '0;
    cur_row  = '0;
    failures = 0;
    blank_screen();
  endfunction

  function void blank_screen();
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) cells[i] = {attr, tcw_pkg::BLANK_CHAR};
  endfunction

  function void set_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
    attr = value;
  endfunction

  function void note_transfer(tcw_pkg::in_item_t it);
    tcw_pkg::out_item_t         res;
    logic [tcw_pkg::CELL_W-1:0] cell_val;
    int unsigned                i;
    int unsigned                pos;
    int unsigned                last_row;
    cell_val = '0;
    last_row = tcw_pkg::ROWS - 1;
    case (it.command)
      tcw_pkg::CMD_PUT: begin
        if (it.char_code == tcw_pkg::NEWLINE_CHAR) begin
          cur_col = '0;
          cur_row = cur_row + 1'b1;
        end else begin
          cells[cur_row * tcw_pkg::COLUMNS + cur_col] = {attr, it.char_code};
          cur_col = cur_col + 1'b1;
        end
        if (cur_col >= tcw_pkg::COLUMNS) begin
          cur_col = '0;
          cur_row = cur_row + 1'b1;
        end
        if (cur_row >= tcw_pkg::ROWS) begin
          // scroll up one line and blank the bottom row
          i = 0;
          while (i + tcw_pkg::COLUMNS < tcw_pkg::CELL_COUNT) begin
            cells[i] = cells[i + tcw_pkg::COLUMNS];
            i++;
          end
          while (i < tcw_pkg::CELL_COUNT) begin
            cells[i] = {attr, tcw_pkg::BLANK_CHAR};
            i++;
          end
          cur_col = '0;
          cur_row = last_row[tcw_pkg::ROW_W-1:0];
        end
      end
      tcw_pkg::CMD_READ: begin
        if (it.read_col < tcw_pkg::COLUMNS && it.read_row < tcw_pkg::ROWS)
          cell_val = cells[it.read_row * tcw_pkg::COLUMNS + it.read_col];
      end
      tcw_pkg::CMD_CLEAR: begin
        blank_screen();
      end
      default: ;
    endcase
    pos                 = cur_row * tcw_pkg::COLUMNS + cur_col;
    res.cursor_col      = cur_col;
    res.cursor_row      = cur_row;
    res.cursor_position = pos[tcw_pkg::POS_W-1:0];
    res.cell_value      = cell_val;
    expected_q.push_back(res);
  endfunction

  function void flag(string what, tcw_pkg::out_item_t exp, tcw_pkg::out_item_t got);
    failures++;
    if (failures <= 10)
      $display("%0t %s: expected col=%0d row=%0d pos=%0d cell=%h, %s col=%0d row=%0d %s",
               $time, what, exp.cursor_col, exp.cursor_row, exp.cursor_position,
               exp.cell_value, "got", got.cursor_col, got.cursor_row,
               $sformatf("pos=%0d cell=%h", got.cursor_position, got.cell_value));
  endfunction

  function void check_result(tcw_pkg::out_item_t got);
    tcw_pkg::out_item_t exp;
    if (expected_q.size() == 0) begin
      flag("unexpected result", '0, got);
    end else begin
      exp = expected_q.pop_front();
      if (got.cursor_col !== exp.cursor_col || got.cursor_row !== exp.cursor_row ||
          got.cursor_position !== exp.cursor_position || got.cell_value !== exp.cell_value)
        flag("result mismatch", exp, got);
    end
  endfunction

  function void close_out();
    if (expected_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_q.size());
      failures += expected_q.size();
    end
  endfunction
endclass

module tb;
  import tcw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int unsigned LIMIT = 6000000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                cfg_we;
  logic [ATTR_W-1:0]   cfg_wdata;

  console_scoreboard   sb;
  in_item_t            stim_q[$];
  int unsigned         cycles;

  text_console_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("text_console_writer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                         logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    in_item_t it;
    it.command   = cmd;
    it.char_code = ch;
    it.read_col  = col;
    it.read_row  = row;
    return it;
  endfunction

  function automatic in_item_t random_item(bit many_newlines);
    in_item_t    it;
    int unsigned pick;
    int unsigned nl_pct;
    it     = in_item_t'($urandom);
    pick   = $urandom_range(99);
    nl_pct = many_newlines ? 25 : 1;
    if (pick < nl_pct) begin
      it.command   = CMD_PUT;
      it.char_code = NEWLINE_CHAR;
    end else if (pick < 70) begin
      it.command = CMD_PUT;
    end else if (pick < 94) begin
      it.command = CMD_READ;
      if ($urandom_range(4) != 0) begin
        it.read_col = COL_W'($urandom_range(COLUMNS - 1));
        it.read_row = ROW_W'($urandom_range(ROWS - 1));
      end
    end else if (pick < 96) begin
      it.command = CMD_CLEAR;
    end else begin
      it.command = CMD_NOP;
    end
    return it;
  endfunction

  // send everything queued, in bursts with random gaps
  task automatic drive_stim();
    int unsigned burst;
    int unsigned gap;
    while (stim_q.size() != 0) begin
      burst = ($urandom_range(3) == 0) ? 60 : $urandom_range(12, 1);
      while (burst > 0 && stim_q.size() != 0) begin
        start   <= 1'b1;
        in_item <= stim_q[0];
        do @(posedge clk); while (busy);
        sb.note_transfer(stim_q.pop_front());
        burst--;
      end
      gap = $urandom_range(8);
      if (gap != 0) begin
        start   <= 1'b0;
        in_item <= in_item_t'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    while (sb.expected_q.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_attribute(value);
  endtask

  task automatic random_phase(int unsigned count);
    bit many_newlines;
    many_newlines = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 35 == 0) many_newlines = 1'($urandom_range(1));
      stim_q.push_back(random_item(many_newlines));
    end
    drive_stim();
  endtask

  initial begin
    sb        = new();
    cycles    = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of the read window, odd characters, the spare command, clear
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd0,   5'd0));
    stim_q.push_back(make_item(CMD_READ,  8'hFF, 7'd79,  5'd24));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd80,  5'd0));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd0,   5'd25));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd127, 5'd31));
    stim_q.push_back(make_item(CMD_PUT,   8'h00, 7'd127, 5'd31));
    stim_q.push_back(make_item(CMD_PUT,   8'hFF, 7'd0,   5'd0));
    stim_q.push_back(make_item(CMD_PUT,   8'h80, 7'd0,   5'd0));
    stim_q.push_back(make_item(CMD_PUT,   NEWLINE_CHAR, 7'd0, 5'd0));
    stim_q.push_back(make_item(CMD_PUT,   8'h7F, 7'd0,   5'd0));
    stim_q.push_back(make_item(CMD_NOP,   8'hFF, 7'd127, 5'd31));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd0,   5'd0));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd1,   5'd0));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd2,   5'd0));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd0,   5'd1));
    stim_q.push_back(make_item(CMD_CLEAR, 8'hFF, 7'd127, 5'd31));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd1,   5'd0));
    stim_q.push_back(make_item(CMD_PUT,   8'h41, 7'd0,   5'd0));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd1,   5'd1));
    stim_q.push_back(make_item(CMD_READ,  8'h00, 7'd79,  5'd31));
    drive_stim();

    write_attribute(8'h00);
    random_phase(140);
    write_attribute(8'hFF);
    random_phase(140);
    write_attribute(ATTR_W'($urandom_range(255)));
    random_phase(140);
    write_attribute(ATTR_W'($urandom_range(255)));
    random_phase(140);
    write_attribute(RESET_ATTR);
    random_phase(140);

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("text_console_writer verification clean");
    end else begin
      $display("text_console_writer verification failed");
    end
    $finish;
  end
endmodule
